[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FSIP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FSIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fsip_pkg.sv]
// Shared constants, types and helpers for the format string integer printer.
// No dependencies; every other file but assert_macros.svh imports this package.
`default_nettype none

package fsip_pkg;

  localparam int MAX_WIDTH_DEF = 63;   // default width saturation
  localparam int W_BITS        = 6;    // width field
  localparam int PTR_MAX_W     = 62;   // 64 chars per item minus "0x"
  localparam int ARG_BITS      = 64;
  localparam int SHORT_BITS    = 32;
  localparam int DIG_N         = 20;   // decimal digits of a 64-bit value
  localparam int DIG_BITS      = DIG_N * 4;
  localparam int CNT_W         = 5;    // holds 0..DIG_N

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_L = 8'h4c;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_I       = 8'h69;
  localparam logic [7:0] CH_L       = 8'h6c;
  localparam logic [7:0] CH_P       = 8'h70;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_Z       = 8'h7a;

  // Digit formatting controls handed to the emitter on load.
  typedef struct packed {
    logic              upper;
    logic              wg;      // width given
    logic              zp;      // zero pad
    logic [W_BITS-1:0] w;       // effective width
  } emit_cfg_t;

  // One character beat from the emitter.
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       last;
  } char_beat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] alpha;
    alpha = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d < 4'd10) begin
      digit_char = CH_ZERO + {4'b0, d};
    end else begin
      digit_char = alpha + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/fsip_if.sv]
// Valid/ready channel interfaces for the format input and the character output.
// Depends on fsip_pkg for the field widths.
`default_nettype none

interface fsip_in_if;
  import fsip_pkg::*;
  logic                valid;
  logic                ready;
  logic [7:0]          fmt_byte;
  logic [ARG_BITS-1:0] arg_value;

  modport source (output valid, output fmt_byte, output arg_value, input ready);
  modport sink   (input valid, input fmt_byte, input arg_value, output ready);
endinterface

interface fsip_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  logic       error;

  modport source (output valid, output out_char, output last, output error, input ready);
  modport sink   (input valid, input out_char, input last, input error, output ready);
endinterface

`default_nettype wire

[rtl/fsip_bcd_conv.sv]
// Bit-serial binary to BCD converter (shift and add-3), one argument bit per cycle.
// Depends on fsip_pkg.
`default_nettype none

module fsip_bcd_conv (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           short_mode,
  input  logic [fsip_pkg::ARG_BITS-1:0]  bin_in,
  output logic                           busy,
  output logic [fsip_pkg::DIG_BITS-1:0]  bcd
);
  import fsip_pkg::*;

  localparam int STEP_W = $clog2(ARG_BITS);

  logic [ARG_BITS-1:0] shreg;
  logic [DIG_BITS-1:0] adj;
  logic [STEP_W-1:0]   steps;

  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && steps == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bcd <= '0;
      if (short_mode) begin
        shreg <= {bin_in[SHORT_BITS-1:0], {(ARG_BITS-SHORT_BITS){1'b0}}};
        steps <= STEP_W'(SHORT_BITS - 1);
      end else begin
        shreg <= bin_in;
        steps <= STEP_W'(ARG_BITS - 1);
      end
    end else if (busy) begin
      bcd   <= {adj[DIG_BITS-2:0], shreg[ARG_BITS-1]};
      shreg <= {shreg[ARG_BITS-2:0], 1'b0};
      steps <= steps - 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/fsip_digit_emit.sv]
// Digit emitter: strips leading zeros, truncates to width, pads, then shifts
// digits out one nibble per beat, most significant first. Depends on fsip_pkg.
`default_nettype none

module fsip_digit_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  fsip_pkg::emit_cfg_t           cfg,
  input  logic [fsip_pkg::DIG_BITS-1:0] digits,
  input  logic                          take,
  output fsip_pkg::char_beat_t          beat
);
  import fsip_pkg::*;

  typedef enum logic [4:0] {
    E_IDLE  = 5'b00001,
    E_STRIP = 5'b00010,
    E_TRUNC = 5'b00100,
    E_PAD   = 5'b01000,
    E_EMIT  = 5'b10000
  } emit_state_t;

  emit_state_t         state, state_next;
  logic [DIG_BITS-1:0] dig, dig_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [W_BITS-1:0]   pads, pads_next;
  emit_cfg_t           cfg_r;
  logic [3:0]          top_dig;
  logic [W_BITS-1:0]   cnt_ext;

  assign top_dig = dig[DIG_BITS-1 -: 4];
  assign cnt_ext = W_BITS'(cnt);

  always_comb begin
    state_next = state;
    dig_next   = dig;
    cnt_next   = cnt;
    pads_next  = pads;
    beat       = '0;
    case (state)
      E_IDLE: begin
        if (load) begin
          dig_next   = digits;
          cnt_next   = CNT_W'(DIG_N);
          state_next = E_STRIP;
        end
      end
      E_STRIP: begin
        // always keep one digit, even for zero
        if (cnt > CNT_W'(1) && top_dig == 4'd0) begin
          dig_next = {dig[DIG_BITS-5:0], 4'b0};
          cnt_next = cnt - 1'b1;
        end else begin
          state_next = E_TRUNC;
        end
      end
      E_TRUNC: begin
        // keep only the low w digits
        if (cfg_r.wg && cnt_ext > cfg_r.w) begin
          dig_next = {dig[DIG_BITS-5:0], 4'b0};
          cnt_next = cnt - 1'b1;
        end else if (cfg_r.wg && cfg_r.zp && cfg_r.w > cnt_ext) begin
          pads_next  = cfg_r.w - cnt_ext;
          state_next = E_PAD;
        end else begin
          state_next = E_EMIT;
        end
      end
      E_PAD: begin
        beat.valid = 1'b1;
        beat.ch    = CH_ZERO;
        if (take) begin
          pads_next = pads - 1'b1;
          if (pads == W_BITS'(1)) begin
            state_next = E_EMIT;
          end
        end
      end
      E_EMIT: begin
        beat.valid = 1'b1;
        beat.ch    = digit_char(top_dig, cfg_r.upper);
        beat.last  = (cnt == CNT_W'(1));
        if (take) begin
          dig_next = {dig[DIG_BITS-5:0], 4'b0};
          cnt_next = cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state_next = E_IDLE;
          end
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    dig  <= dig_next;
    cnt  <= cnt_next;
    pads <= pads_next;
    if (load && state == E_IDLE) begin
      cfg_r <= cfg;
    end
  end

endmodule

`default_nettype wire

[rtl/format_string_integer_printer_unit.sv]
// Channel | dir | beat payload                  | accepted when
// fmt     | in  | fmt_byte[8], arg_value[64]    | fmt.valid && fmt.ready
// res     | out | out_char[8], last, error      | res.valid && res.ready
//
// One byte at a time; a byte that moves the parser or gives one character is
// accepted, then decoded. Numbers then emit any prefix chars, load the emitter,
// strip leading zeros, drop digits beyond the width, then give the characters
// one at a time; decimal loads wait for the serial BCD unit, longer for 64-bit.
// rst is synchronous. Stalls on res hold the sequencer; the output register lets
// the next byte be accepted while the final character still waits.
//
// Top level of the printer: parser, sequencer and output register.
// Depends on fsip_pkg, fsip_if, fsip_bcd_conv and fsip_digit_emit.
`default_nettype none

module format_string_integer_printer_unit #(
  parameter int unsigned MAX_WIDTH = fsip_pkg::MAX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fsip_in_if.sink    fmt,
  fsip_out_if.source res
);
  import fsip_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_PREFIX = 5'b00100,
    S_CONV   = 5'b01000,
    S_DIGITS = 5'b10000
  } seq_state_t;

  typedef enum logic [3:0] {
    PH_PLAIN = 4'b0001,
    PH_PCT   = 4'b0010,
    PH_WIDTH = 4'b0100,
    PH_SIZE  = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    SZ_INT   = 2'd0,
    SZ_LONG  = 2'd1,
    SZ_LLONG = 2'd2,
    SZ_SIZE  = 2'd3
  } size_kind_t;

  seq_state_t          state, state_next;
  phase_t              phase, phase_next;
  size_kind_t          size, size_next;
  logic                zp, zp_next, wg, wg_next;
  logic [W_BITS-1:0]   wv, wv_next;

  logic [7:0]          fbyte_r;
  logic [ARG_BITS-1:0] arg_r;
  logic [ARG_BITS-1:0] num_r;
  logic                is_dec_r, ptr_r, empty_r;
  logic [1:0]          pre_cnt, pre_cnt_next;
  emit_cfg_t           ecfg_r;

  logic                out_valid, out_last, out_error;
  logic [7:0]          out_char;

  // decode of the held byte
  logic                is_digit, pct_or_w, size_letter;
  logic                d_plain, d_flag, d_width, d_size, d_ll, d_conv;
  logic                cv_pct, cv_chr, cv_sdec, cv_udec, cv_hex, cv_ptr, cv_bad, cv_num;
  logic                single_out;
  logic [7:0]          single_char;
  logic [9:0]          w10;
  logic [W_BITS-1:0]   wv_sat, w_eff;
  logic                long_arg, neg, empty;
  logic [ARG_BITS-1:0] base_v, mag;

  // sequencer controls
  logic                can_push, push, push_last, push_err;
  logic [7:0]          push_char;
  logic                dec_go, num_setup, bcd_start, bcd_busy, emit_load, emit_take;
  logic [DIG_BITS-1:0] bcd, emit_digits;
  char_beat_t          beat;

  assign is_digit    = (fbyte_r >= CH_ZERO) && (fbyte_r <= CH_NINE);
  assign pct_or_w    = (phase == PH_PCT) || (phase == PH_WIDTH);
  assign size_letter = (fbyte_r == CH_L) || (fbyte_r == CH_UPPER_L) || (fbyte_r == CH_Z);

  assign d_plain = (phase == PH_PLAIN);
  assign d_flag  = (phase == PH_PCT) && (fbyte_r == CH_ZERO);
  assign d_width = pct_or_w && is_digit && !d_flag;
  assign d_size  = pct_or_w && size_letter;
  assign d_ll    = (phase == PH_SIZE) && (fbyte_r == CH_L) && (size == SZ_LONG);
  assign d_conv  = !(d_plain || d_flag || d_width || d_size || d_ll);

  assign cv_pct  = (fbyte_r == CH_PCT);
  assign cv_chr  = (fbyte_r == CH_C);
  assign cv_sdec = (fbyte_r == CH_D) || (fbyte_r == CH_I);
  assign cv_udec = (fbyte_r == CH_U);
  assign cv_hex  = (fbyte_r == CH_X) || (fbyte_r == CH_UPPER_X);
  assign cv_ptr  = (fbyte_r == CH_P);
  assign cv_bad  = !(cv_pct || cv_chr || cv_sdec || cv_udec || cv_hex || cv_ptr);
  assign cv_num  = d_conv && (cv_sdec || cv_udec || cv_hex || cv_ptr);

  assign single_out  = (d_plain && fbyte_r != CH_PCT && fbyte_r != CH_NUL)
                    || (d_conv && (cv_pct || cv_chr || cv_bad));
  assign single_char = d_plain ? fbyte_r :
                       !d_conv ? CH_NUL :
                       cv_pct  ? CH_PCT :
                       cv_chr  ? arg_r[7:0] : CH_NUL;

  // width accumulate: wv * 10 + digit, saturating
  assign w10    = {1'b0, wv, 3'b000} + {3'b000, wv, 1'b0} + {6'b0, fbyte_r[3:0]};
  assign wv_sat = (w10 > 10'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH) : w10[W_BITS-1:0];
  assign w_eff  = (cv_ptr && wv > W_BITS'(PTR_MAX_W)) ? W_BITS'(PTR_MAX_W) : wv;
  assign empty  = wg && (w_eff == '0);

  assign long_arg = (size != SZ_INT) || cv_ptr;
  assign base_v   = long_arg ? arg_r :
                    cv_sdec  ? {{(ARG_BITS-SHORT_BITS){arg_r[SHORT_BITS-1]}},
                                arg_r[SHORT_BITS-1:0]} :
                               {{(ARG_BITS-SHORT_BITS){1'b0}}, arg_r[SHORT_BITS-1:0]};
  assign neg      = cv_sdec && base_v[ARG_BITS-1];
  assign mag      = neg ? (ARG_BITS'(0) - base_v) : base_v;

  assign can_push    = !out_valid || res.ready;
  assign dec_go      = (state == S_DECODE) && (!single_out || can_push);
  assign num_setup   = dec_go && cv_num;
  assign bcd_start   = num_setup && (cv_sdec || cv_udec);
  assign emit_digits = is_dec_r ? bcd : DIG_BITS'(num_r);

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    size_next    = size;
    zp_next      = zp;
    wg_next      = wg;
    wv_next      = wv;
    pre_cnt_next = pre_cnt;
    push         = 1'b0;
    push_char    = CH_NUL;
    push_last    = 1'b0;
    push_err     = 1'b0;
    emit_load    = 1'b0;
    emit_take    = 1'b0;
    case (state)
      S_IDLE: begin
        if (fmt.valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (dec_go) begin
          push       = single_out;
          push_char  = single_char;
          push_last  = 1'b1;
          push_err   = d_conv && cv_bad;
          state_next = S_IDLE;
          if (d_plain) begin
            if (fbyte_r == CH_PCT) begin
              phase_next = PH_PCT;
            end
          end else if (d_flag) begin
            zp_next    = 1'b1;
            phase_next = PH_WIDTH;
          end else if (d_width) begin
            wv_next    = wv_sat;
            wg_next    = 1'b1;
            phase_next = PH_WIDTH;
          end else if (d_size) begin
            size_next  = (fbyte_r == CH_L) ? SZ_LONG :
                         (fbyte_r == CH_UPPER_L) ? SZ_LLONG : SZ_SIZE;
            phase_next = PH_SIZE;
          end else if (d_ll) begin
            size_next = SZ_LLONG;
          end else begin
            phase_next = PH_PLAIN;
            size_next  = SZ_INT;
            zp_next    = 1'b0;
            wg_next    = 1'b0;
            wv_next    = '0;
            if (cv_num) begin
              pre_cnt_next = neg ? 2'd1 : cv_ptr ? 2'd2 : 2'd0;
              if (neg || cv_ptr) begin
                state_next = S_PREFIX;
              end else if (!empty) begin
                state_next = S_CONV;
              end
            end
          end
        end
      end
      S_PREFIX: begin
        push      = can_push;
        push_char = (pre_cnt == 2'd2) ? CH_ZERO : (ptr_r ? CH_X : CH_MINUS);
        push_last = (pre_cnt == 2'd1) && empty_r;
        if (can_push) begin
          pre_cnt_next = pre_cnt - 1'b1;
          if (pre_cnt == 2'd1) begin
            state_next = empty_r ? S_IDLE : S_CONV;
          end
        end
      end
      S_CONV: begin
        if (!is_dec_r || !bcd_busy) begin
          emit_load  = 1'b1;
          state_next = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (beat.valid && can_push) begin
          push      = 1'b1;
          push_char = beat.ch;
          push_last = beat.last;
          emit_take = 1'b1;
          if (beat.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_PLAIN;
      size      <= SZ_INT;
      zp        <= 1'b0;
      wg        <= 1'b0;
      wv        <= '0;
      pre_cnt   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      size    <= size_next;
      zp      <= zp_next;
      wg      <= wg_next;
      wv      <= wv_next;
      pre_cnt <= pre_cnt_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fmt.valid && fmt.ready) begin
      fbyte_r <= fmt.fmt_byte;
      arg_r   <= fmt.arg_value;
    end
    if (num_setup) begin
      num_r        <= mag;
      is_dec_r     <= cv_sdec || cv_udec;
      ptr_r        <= cv_ptr;
      empty_r      <= empty;
      ecfg_r.upper <= (fbyte_r == CH_UPPER_X);
      ecfg_r.wg    <= wg;
      ecfg_r.zp    <= zp;
      ecfg_r.w     <= w_eff;
    end
    if (push) begin
      out_char  <= push_char;
      out_last  <= push_last;
      out_error <= push_err;
    end
  end

  fsip_bcd_conv u_bcd (
    .clk        (clk),
    .rst        (rst),
    .start      (bcd_start),
    .short_mode (size == SZ_INT),
    .bin_in     (mag),
    .busy       (bcd_busy),
    .bcd        (bcd)
  );

  fsip_digit_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .load   (emit_load),
    .cfg    (ecfg_r),
    .digits (emit_digits),
    .take   (emit_take),
    .beat   (beat)
  );

  assign fmt.ready    = (state == S_IDLE);
  assign res.valid    = out_valid;
  assign res.out_char = out_char;
  assign res.last     = out_last;
  assign res.error    = out_error;

endmodule

`default_nettype wire

[rtl/fsip_checker.sv]
// Port-level checks for the printer, attached to the top level by bind.
// Depends on fsip_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fsip_checker (
  input logic       clk,
  input logic       rst,
  input logic       fmt_valid,
  input logic       fmt_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_char,
  input logic       res_last,
  input logic       res_error
);
  import fsip_pkg::*;

  // an error beat is always the only, final beat of its item, with a NUL char
  `FSIP_ASSERT_IMP(a_err_beat, res_valid && res_error, res_last && (res_char == CH_NUL), "error beat not final or char not NUL")

  // one byte in flight: ready drops right after a byte is taken
  `FSIP_ASSERT_NEXT(a_one_item, fmt_valid && fmt_ready, !fmt_ready, "input ready held after accept")

  // while ready for a new byte, anything still waiting at the output ends its item
  `FSIP_ASSERT_IMP(a_idle_last, fmt_ready && res_valid, res_last, "input ready with a non-final beat pending")

  `FSIP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_char) && $stable(res_last) && $stable(res_error), "stalled output beat changed")

endmodule

bind format_string_integer_printer_unit fsip_checker u_fsip_checker (
  .clk       (clk),
  .rst       (rst),
  .fmt_valid (fmt.valid),
  .fmt_ready (fmt.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_char  (res.out_char),
  .res_last  (res.last),
  .res_error (res.error)
);

`default_nettype wire
